// ===== rtl/rsd_pkg.sv =====
`timescale 1ns / 1ps

package rsd_pkg;

    // Internal address width; frame buffer addresses wrap at this many bits.
    localparam int ADDRESS_BITS = 24;

    // Fixed field widths.
    localparam int SPAN_ADDR_W = 24;
    localparam int COLOR_W     = 8;
    localparam int LEN_W       = 8;
    localparam int ORIGIN_W    = 12;
    localparam int DIM_W       = 13;
    localparam int COL_W       = 12;
    localparam int PIXCNT_W    = 25;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int CFG_IDX_W   = 3;

    // Clamp limits for the image size.
    localparam logic [DIM_W-1:0] WIDTH_MIN  = DIM_W'(8);
    localparam logic [DIM_W-1:0] DIM_MAX    = DIM_W'(4096);
    localparam logic [DIM_W-1:0] HEIGHT_MIN = DIM_W'(1);

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0] PITCH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(8);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    // Operands of the shared multiply and add unit.
    typedef struct packed {
        logic [DIM_W-1:0]        mul_a;
        logic [DIM_W-1:0]        mul_b;
        logic [ADDRESS_BITS-1:0] add_a;
        logic [ADDRESS_BITS-1:0] add_b;
    } rsd_alu_op_t;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] lo
    );
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v < lo)
            begin
                r = lo;
            end
            else if (v > DIM_MAX)
            begin
                r = DIM_MAX;
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/rsd_alu.sv =====
`timescale 1ns / 1ps

// Shared arithmetic unit: one registered 13x13 multiplier and one address adder.
module rsd_alu
    import rsd_pkg::*;
(
    input  logic                    clk,
    input  rsd_alu_op_t             op,
    output logic [PROD_W-1:0]       prod,
    output logic [ADDRESS_BITS-1:0] sum
);

    logic [PROD_W-1:0] prod_reg;

    // The product is registered before anyone uses it.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op.mul_a) * PROD_W'(op.mul_b);
    end

    assign prod = prod_reg;

    // Address adder wraps at the address width.
    assign sum = op.add_a + op.add_b;

endmodule

// ===== rtl/rle_image_span_decoder.sv =====
`timescale 1ns / 1ps

// Run-length image span decoder.
// The slave stream carries one token per word: tdata holds color and run length,
// tuser says whether the token is a run (1) or a single literal pixel (0).
// The master stream carries one fill span per word: tdata holds address, color
// and length, tlast marks the final span of a token and tuser flags the span
// that completes the image. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must do this while the decoder is idle (not enforced).
// A token is accepted in IDLE and checked against the image size in CHECK; a token
// that starts a new image also passes START and LOAD (origin multiply, then add).
// Each span then uses the shared adder in SPAN, and each span that ends
// at the right edge of the image uses the adder again in ROW for the row step.
// After CHECK (and START and LOAD at an image start), SPAN registers the first
// span onto the master side. A token with a zero run length produces no span.
// The span output is a register: the next token may be accepted while the last
// span still waits. When the receiver stalls, span generation holds.
// After reset the configuration and control registers hold their default values
// and the next token starts a new image at the origin.
module rle_image_span_decoder
    import rsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input token stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [7:0] color, [15:8] run_length
    input  logic                 s_tuser,   // [0] is_run
    // Output span stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [23:0] span_address, [31:24] span_color,
                                            // [39:32] span_length
    output logic                 m_tlast,   // last_span
    output logic                 m_tuser,   // [0] image_done
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_START = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_SPAN  = 6'b010000,
        ST_ROW   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ORIGIN_W-1:0] origin_x_reg, origin_y_reg;
    logic [DIM_W-1:0]    pitch_reg, width_reg, height_reg;

    logic [ADDRESS_BITS-1:0] row_reg, row_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [PIXCNT_W-1:0]     pw_reg, pw_next;
    logic [PIXCNT_W-1:0]     size_reg, size_next;
    logic [COLOR_W-1:0]      color_reg;
    logic [LEN_W-1:0]        rem_reg, rem_next;

    logic                    out_valid_reg, out_valid_next;
    logic [SPAN_ADDR_W-1:0]  out_addr_reg;
    logic [COLOR_W-1:0]      out_color_reg;
    logic [LEN_W-1:0]        out_len_reg;
    logic                    out_last_reg, out_done_reg;

    rsd_alu_op_t             alu_op;
    logic [PROD_W-1:0]       prod;
    logic [ADDRESS_BITS-1:0] sum;

    logic [DIM_W-1:0]    w_use, h_use;
    logic [DIM_W-1:0]    room;
    logic [LEN_W-1:0]    take;
    logic [DIM_W-1:0]    col_sum;
    logic [PIXCNT_W-1:0] pw_add;
    logic                out_free;
    logic                accept;
    logic                span_fire;
    logic                start_due;

    assign w_use    = clamp_dim(width_reg, WIDTH_MIN);
    assign h_use    = clamp_dim(height_reg, HEIGHT_MIN);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            pitch_reg    <= PITCH_RESET;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg <= cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg <= cfg_data[ORIGIN_W-1:0];
                REG_LINE_PITCH:   pitch_reg    <= cfg_data;
                REG_IMAGE_WIDTH:  width_reg    <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_op.mul_a = w_use;
        alu_op.mul_b = h_use;
        alu_op.add_a = row_reg;
        alu_op.add_b = ADDRESS_BITS'(pitch_reg);
        case (state_reg)
            ST_START:
            begin
                alu_op.mul_a = DIM_W'(origin_y_reg);
                alu_op.mul_b = pitch_reg;
            end
            ST_LOAD:
            begin
                alu_op.add_a = ADDRESS_BITS'(prod);
                alu_op.add_b = ADDRESS_BITS'(origin_x_reg);
            end
            ST_SPAN:
            begin
                alu_op.add_b = ADDRESS_BITS'(col_reg);
            end
            default: ;
        endcase
    end

    rsd_alu u_alu (
        .clk  (clk),
        .op   (alu_op),
        .prod (prod),
        .sum  (sum)
    );

    // Span sizing against the right edge.
    assign room      = w_use - DIM_W'(col_reg);
    assign take      = (DIM_W'(rem_reg) < room) ? rem_reg : room[LEN_W-1:0];
    assign col_sum   = DIM_W'(col_reg) + DIM_W'(take);
    assign pw_add    = pw_reg + PIXCNT_W'(take);
    assign span_fire = (state_reg == ST_SPAN) && out_free;
    assign start_due = (pw_reg == '0) || (PROD_W'(pw_reg) >= prod);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pw_next        = pw_reg;
        size_next      = size_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next   = s_tuser ? s_tdata[15:8] : LEN_W'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // The product register holds width times height here.
                size_next = PIXCNT_W'(prod);
                if (start_due)
                begin
                    state_next = ST_START;
                end
                else if (rem_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (DIM_W'(col_reg) >= w_use)
                begin
                    // Width shrank under the column: step to the next row.
                    row_next   = sum;
                    col_next   = '0;
                    state_next = ST_SPAN;
                end
                else
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_START:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                row_next   = sum;
                col_next   = '0;
                pw_next    = '0;
                state_next = (rem_reg == '0) ? ST_IDLE : ST_SPAN;
            end
            ST_SPAN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pw_next        = pw_add;
                    rem_next       = rem_reg - take;
                    if (col_sum >= w_use)
                    begin
                        col_next   = '0;
                        state_next = ST_ROW;
                    end
                    else
                    begin
                        col_next   = col_sum[COL_W-1:0];
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ROW:
            begin
                row_next   = sum;
                state_next = (rem_reg == '0) ? ST_IDLE : ST_SPAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            pw_reg        <= '0;
            size_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            pw_reg        <= pw_next;
            size_reg      <= size_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Token color and output word payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            color_reg <= s_tdata[7:0];
        end
        if (span_fire)
        begin
            out_addr_reg  <= SPAN_ADDR_W'(sum);
            out_color_reg <= color_reg;
            out_len_reg   <= take;
            out_last_reg  <= (rem_reg == take);
            out_done_reg  <= (pw_reg < size_reg) && (pw_add >= size_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_color_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule
